/* rtl/rad_pkg.sv */
// package of shared types, widths and codes for the apogee detector
`default_nettype none

package rad_pkg;

    // field widths
    localparam int AltW   = 21;
    localparam int MarW   = 16;
    localparam int CntW   = 17;
    localparam int ActW   = 2;
    localparam int CauseW = 2;
    localparam int CfgIdxW = 3;
    // width of the signed compare arithmetic
    localparam int CalcW  = AltW + 2;

    // tdata widths, padded to whole bytes
    localparam int InDataW  = 24;
    localparam int OutDataW = 48;

    // action codes
    localparam logic [ActW-1:0] ActSample = 2'd0;
    localparam logic [ActW-1:0] ActArm    = 2'd1;
    localparam logic [ActW-1:0] ActDisarm = 2'd2;

    // stop causes
    localparam logic [CauseW-1:0] StopNone      = 2'd0;
    localparam logic [CauseW-1:0] StopTouchdown = 2'd1;
    localparam logic [CauseW-1:0] StopTimeLimit = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegLaunchMargin   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegApogeeMargin   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegTouchdownMargin = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDescentTol     = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMaxSamples     = 3'd4;

    // register reset values
    localparam logic [MarW-1:0] LaunchMarginRst    = 16'd30;
    localparam logic [MarW-1:0] ApogeeMarginRst    = 16'd50;
    localparam logic [MarW-1:0] TouchdownMarginRst = 16'd100;
    localparam logic [MarW-1:0] DescentTolRst      = 16'd10;
    localparam logic [MarW-1:0] MaxSamplesRst      = 16'd3000;

    // saturation value of the sample count
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    typedef struct packed {
        logic [MarW-1:0] lift_thr;
        logic [MarW-1:0] drop_thr;
        logic [MarW-1:0] land_thr;
        logic [MarW-1:0] descent_tol;
        logic [MarW-1:0] max_samples;
    } rad_cfg_t;

    typedef struct packed {
        logic                     armed;
        logic                     launched;
        logic                     deploy;
        logic signed [AltW-1:0]   apogee_cm;
        logic                     log_valid;
        logic [CntW-1:0]          elapsed_samples;
        logic [CauseW-1:0]        stop_cause;
    } rad_result_t;

endpackage

`default_nettype wire

/* rtl/rad_cfg_regs.sv */
// configuration register bank of the apogee detector
`default_nettype none

module rad_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rad_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rad_pkg::MarW-1:0]     cfg_data,
    output rad_pkg::rad_cfg_t                 cfg
);

    rad_pkg::rad_cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lift_thr    <= rad_pkg::LaunchMarginRst;
            cfg_reg.drop_thr    <= rad_pkg::ApogeeMarginRst;
            cfg_reg.land_thr    <= rad_pkg::TouchdownMarginRst;
            cfg_reg.descent_tol <= rad_pkg::DescentTolRst;
            cfg_reg.max_samples <= rad_pkg::MaxSamplesRst;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rad_pkg::RegLaunchMargin:    cfg_reg.lift_thr    <= cfg_data;
                rad_pkg::RegApogeeMargin:    cfg_reg.drop_thr    <= cfg_data;
                rad_pkg::RegTouchdownMargin: cfg_reg.land_thr    <= cfg_data;
                rad_pkg::RegDescentTol:      cfg_reg.descent_tol <= cfg_data;
                rad_pkg::RegMaxSamples:      cfg_reg.max_samples <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/rad_flight_core.sv */
// flight state, per-item decision logic and result register
`default_nettype none

module rad_flight_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rad_pkg::rad_cfg_t                  cfg,
    input  wire logic                               item_valid,
    input  wire logic [rad_pkg::ActW-1:0]           action,
    input  wire logic signed [rad_pkg::AltW-1:0]    altitude_cm,
    output logic                                    item_take,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output rad_pkg::rad_result_t                    res
);

    localparam int CW = rad_pkg::CalcW;
    localparam int AW = rad_pkg::AltW;
    localparam int PadM = CW - rad_pkg::MarW;
    localparam int PadA = CW - AW;

    // flight state
    logic                       armed_reg, armed_next;
    logic                       launch_reg, launch_next;
    logic                       apogee_seen_reg, apogee_seen_next;
    logic                       logging_reg, logging_next;
    logic signed [AW-1:0]       peak_reg, peak_next;
    logic signed [AW-1:0]       top_alt_reg, top_alt_next;
    logic signed [AW-1:0]       prev_reg, prev_next;
    logic [rad_pkg::CntW-1:0]   cnt_reg, cnt_next;

    // result register
    logic                       res_valid_reg;
    rad_pkg::rad_result_t       res_reg, res_next;

    // widened operands
    logic signed [CW-1:0] alt_x, peak_x, prev_x;
    logic signed [CW-1:0] lm_x, am_x, tm_x, dt_x;
    logic signed [CW-1:0] apo_thr, fall;
    logic [rad_pkg::CntW-1:0] max_x;
    logic launch_now, touchdown;
    logic [rad_pkg::CauseW-1:0] cause;
    logic deploy;

    // stage moves when the result slot is free
    assign item_take = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign alt_x  = {{PadA{altitude_cm[AW-1]}}, altitude_cm};
    assign prev_x = {{PadA{prev_reg[AW-1]}}, prev_reg};
    assign lm_x   = {{PadM{1'b0}}, cfg.lift_thr};
    assign am_x   = {{PadM{1'b0}}, cfg.drop_thr};
    assign tm_x   = {{PadM{1'b0}}, cfg.land_thr};
    assign dt_x   = {{PadM{1'b0}}, cfg.descent_tol};
    assign max_x  = {1'b0, cfg.max_samples};

    // next state and result for the item in the input register
    always_comb
    begin
        armed_next       = armed_reg;
        launch_next      = launch_reg;
        apogee_seen_next = apogee_seen_reg;
        logging_next     = logging_reg;
        peak_next        = peak_reg;
        top_alt_next     = top_alt_reg;
        prev_next        = prev_reg;
        cnt_next         = cnt_reg;
        deploy           = 1'b0;
        cause            = rad_pkg::StopNone;
        launch_now       = 1'b0;
        touchdown        = 1'b0;
        peak_x           = {{PadA{peak_reg[AW-1]}}, peak_reg};
        apo_thr          = '0;
        fall             = '0;

        unique case (action)
            rad_pkg::ActArm:
            begin
                launch_next      = 1'b0;
                apogee_seen_next = 1'b0;
                logging_next     = 1'b0;
                peak_next        = '0;
                top_alt_next     = '0;
                cnt_next         = '0;
                armed_next       = 1'b1;
            end
            rad_pkg::ActDisarm:
            begin
                armed_next   = 1'b0;
                logging_next = 1'b0;
            end
            rad_pkg::ActSample:
            begin
                if (armed_reg)
                begin
                    prev_next = altitude_cm;
                    // count advances once launched, saturating
                    if (launch_reg && cnt_reg != rad_pkg::CntMax)
                        cnt_next = cnt_reg + 1'b1;
                    // launch detection
                    launch_now = !launch_reg && (alt_x >= lm_x);
                    if (launch_now)
                    begin
                        launch_next  = 1'b1;
                        logging_next = 1'b1;
                        cnt_next     = {{(rad_pkg::CntW-1){1'b0}}, 1'b1};
                    end
                    // peak tracking
                    if (launch_next && alt_x >= peak_x)
                        peak_next = altitude_cm;
                    peak_x  = {{PadA{peak_next[AW-1]}}, peak_next};
                    apo_thr = peak_x - am_x;
                    // apogee detection
                    if (launch_next && !apogee_seen_reg && alt_x <= apo_thr)
                    begin
                        apogee_seen_next = 1'b1;
                        top_alt_next     = peak_next;
                        deploy           = 1'b1;
                    end
                    // stop conditions, touchdown first
                    fall      = prev_x - alt_x;
                    touchdown = launch_next && apogee_seen_next && (alt_x < tm_x)
                                && (fall < dt_x);
                    if (touchdown)
                        cause = rad_pkg::StopTouchdown;
                    else if (cnt_next > max_x)
                        cause = rad_pkg::StopTimeLimit;
                    if (cause != rad_pkg::StopNone)
                    begin
                        logging_next = 1'b0;
                        armed_next   = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        res_next.armed           = armed_next;
        res_next.launched        = launch_next;
        res_next.deploy          = deploy;
        res_next.apogee_cm       = top_alt_next;
        res_next.log_valid       = (action == rad_pkg::ActSample) && armed_reg && logging_next;
        res_next.elapsed_samples = cnt_next;
        res_next.stop_cause      = cause;
    end

    // state update on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            launch_reg      <= 1'b0;
            apogee_seen_reg <= 1'b0;
            logging_reg     <= 1'b0;
            peak_reg        <= '0;
            top_alt_reg     <= '0;
            prev_reg        <= '0;
            cnt_reg         <= '0;
        end
        else if (item_take)
        begin
            armed_reg       <= armed_next;
            launch_reg      <= launch_next;
            apogee_seen_reg <= apogee_seen_next;
            logging_reg     <= logging_next;
            peak_reg        <= peak_next;
            top_alt_reg     <= top_alt_next;
            prev_reg        <= prev_next;
            cnt_reg         <= cnt_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (item_take)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

/* rtl/rocket_apogee_detector.sv */
// top level of the barometric apogee detector
// Takes one beat per clock while the result side keeps up: arm, disarm or
// an altitude sample. Each beat gives exactly one result beat, presented
// once it has passed the input register and then the result register, and
// a new beat may enter every cycle while the result side keeps up. The rate
// is set by the flight state update, which is combinational and registered
// on each taken beat. Configuration writes are always taken and should only
// be issued while no beat is in flight.
`default_nettype none

module rocket_apogee_detector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // sample/command input
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rad_pkg::InDataW-1:0]       s_axis_tdata,  // [20:0] altitude_cm
    input  wire logic [rad_pkg::ActW-1:0]          s_axis_tuser,  // [1:0] action
    // result output
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] armed, [1] launched, [2] deploy, [23:3] apogee_cm, [24] log_valid,
    // [41:25] elapsed_samples, [43:42] stop_cause
    output logic [rad_pkg::OutDataW-1:0]           m_axis_tdata,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rad_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire logic [rad_pkg::MarW-1:0]          cfg_data
);

    localparam int AW = rad_pkg::AltW;
    localparam int ResW = $bits(rad_pkg::rad_result_t);

    rad_pkg::rad_cfg_t    cfg;
    rad_pkg::rad_result_t res;

    logic                          in_valid_reg;
    logic [rad_pkg::ActW-1:0]      in_action_reg;
    logic signed [AW-1:0]          in_alt_reg;
    logic                          item_take;

    rad_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register accepts whenever it is empty or moving on
    assign s_axis_tready = !in_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_alt_reg    <= s_axis_tdata[AW-1:0];
        end
    end

    rad_flight_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (in_valid_reg),
        .action      (in_action_reg),
        .altitude_cm (in_alt_reg),
        .item_take   (item_take),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    // result beat packing, lowest field first
    assign m_axis_tdata = {{(rad_pkg::OutDataW-ResW){1'b0}},
                           res.stop_cause, res.elapsed_samples, res.log_valid,
                           res.apogee_cm, res.deploy, res.launched, res.armed};

endmodule

`default_nettype wire

/* rtl/rad_checker.sv */
// port-level checker for the apogee detector and its bind
`default_nettype none

module rad_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [rad_pkg::OutDataW-1:0]      m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // deploy only after launch
    a_deploy_launched: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("deploy without launch");

    // logging only in an armed, launched flight
    a_log_armed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("log beat outside an active flight");

    // a stop ends the flight on the same beat
    a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[43:42] != rad_pkg::StopNone)
        |-> !m_axis_tdata[0] && !m_axis_tdata[24] && m_axis_tdata[1])
        else $error("stop beat still armed or logging");

    // no unknown stop cause
    a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[43:42] == rad_pkg::StopNone)
                       || (m_axis_tdata[43:42] == rad_pkg::StopTouchdown)
                       || (m_axis_tdata[43:42] == rad_pkg::StopTimeLimit))
        else $error("invalid stop cause");

endmodule

bind rocket_apogee_detector rad_checker u_rad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
